>>> rtl/core/lbg_pkg.sv
// ----------------------------------------------------------------------------
// lbg_pkg
// Shared types and constants for the line pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lbg_pkg;

  localparam int unsigned X_W     = 9;
  localparam int unsigned Y_W     = 8;
  localparam int unsigned COL_W   = 16;
  localparam int unsigned M_W     = (X_W > Y_W) ? X_W : Y_W;
  localparam int unsigned E_W     = M_W + 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_e;

  typedef struct packed {
    action_e            action;
    logic [X_W-1:0]     start_x;
    logic [Y_W-1:0]     start_y;
    logic [X_W-1:0]     end_x;
    logic [Y_W-1:0]     end_y;
    logic [COL_W-1:0]   colour;
  } in_word_t;

  typedef struct packed {
    logic [X_W-1:0]     pixel_x;
    logic [Y_W-1:0]     pixel_y;
    logic [COL_W-1:0]   pixel_colour;
    logic               last_pixel;
  } out_word_t;

  typedef struct packed {
    logic               steep;
    logic [M_W-1:0]     major_pos;
    logic [M_W-1:0]     major_end;
    logic [M_W-1:0]     minor_pos;
    logic               minor_down;
    logic [M_W-1:0]     delta_major;
    logic [M_W-1:0]     delta_minor;
    logic [E_W-1:0]     error_init;
    logic [COL_W-1:0]   colour;
  } setup_t;

  typedef struct packed {
    logic               load;
    setup_t             setup;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/lbg_front.sv
// ----------------------------------------------------------------------------
// lbg_front
// Accepts input words, classifies load versus advance and computes the
// line setup for loads before queuing the command.
// ----------------------------------------------------------------------------
`default_nettype none

module lbg_front (
  input  lbg_pkg::in_word_t in_word_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              q_full_i,
  output logic              push_o,
  output lbg_pkg::cmd_t     cmd_o
);
  import lbg_pkg::*;

  logic [M_W-1:0] xa, xb, ya, yb;
  logic [M_W-1:0] dx, dy;
  logic           steep;
  logic [M_W-1:0] ma, na, mb, nb;
  logic [M_W-1:0] m_lo, m_hi, n_lo, n_hi;
  logic [M_W-1:0] d_major;

  always_comb begin
    xa = M_W'(in_word_i.start_x);
    xb = M_W'(in_word_i.end_x);
    ya = M_W'(in_word_i.start_y);
    yb = M_W'(in_word_i.end_y);
    dx = (xa > xb) ? (xa - xb) : (xb - xa);
    dy = (ya > yb) ? (ya - yb) : (yb - ya);
    steep = dy > dx;
    if (steep) begin
      ma = ya; na = xa; mb = yb; nb = xb;
    end else begin
      ma = xa; na = ya; mb = xb; nb = yb;
    end
    if (ma > mb) begin
      m_lo = mb; m_hi = ma; n_lo = nb; n_hi = na;
    end else begin
      m_lo = ma; m_hi = mb; n_lo = na; n_hi = nb;
    end
    d_major = m_hi - m_lo;
  end

  always_comb begin
    cmd_o.load              = (in_word_i.action == ACT_LOAD);
    cmd_o.setup.steep       = steep;
    cmd_o.setup.major_pos   = m_lo;
    cmd_o.setup.major_end   = m_hi;
    cmd_o.setup.minor_pos   = n_lo;
    cmd_o.setup.minor_down  = !(n_lo < n_hi);
    cmd_o.setup.delta_major = d_major;
    cmd_o.setup.delta_minor = (n_lo > n_hi) ? (n_lo - n_hi) : (n_hi - n_lo);
    cmd_o.setup.error_init  = E_W'(0) - {2'b00, 1'b0, d_major[M_W-1:1]};
    cmd_o.setup.colour      = in_word_i.colour;
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

>>> rtl/core/lbg_queue.sv
// ----------------------------------------------------------------------------
// lbg_queue
// Short command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lbg_queue #(
  parameter int unsigned DEPTH = lbg_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lbg_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lbg_pkg::cmd_t cmd_o
);
  import lbg_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lbg_back.sv
// ----------------------------------------------------------------------------
// lbg_back
// Holds the active line, steps the error accumulator once per advance while a
// line is active and registers each pixel word for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lbg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  lbg_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lbg_pkg::out_word_t out_word_o
);
  import lbg_pkg::*;

  logic             busy_q, busy_d;
  setup_t           line_q, line_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_word_q, out_word_d;
  logic             do_load, do_emit;
  logic [E_W-1:0]   err_sum;
  logic             step_minor;
  logic             last;

  assign pop_o   = q_valid_i && (!out_valid_q || !out_stall_i);
  assign do_load = pop_o && cmd_i.load;
  assign do_emit = pop_o && !cmd_i.load && busy_q;

  always_comb begin
    last       = (line_q.major_pos == line_q.major_end);
    err_sum    = line_q.error_init + {2'b00, line_q.delta_minor};
    step_minor = !err_sum[E_W-1] && (err_sum != '0);

    busy_d      = busy_q;
    line_d      = line_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (do_load) begin
      line_d = cmd_i.setup;
      busy_d = 1'b1;
    end else if (do_emit) begin
      out_valid_d = 1'b1;
      out_word_d.pixel_x      = line_q.steep ? X_W'(line_q.minor_pos)
                                             : X_W'(line_q.major_pos);
      out_word_d.pixel_y      = line_q.steep ? Y_W'(line_q.major_pos)
                                             : Y_W'(line_q.minor_pos);
      out_word_d.pixel_colour = line_q.colour;
      out_word_d.last_pixel   = last;
      if (step_minor) begin
        line_d.minor_pos  = line_q.minor_down ? line_q.minor_pos - 1'b1
                                              : line_q.minor_pos + 1'b1;
        line_d.error_init = err_sum - {2'b00, line_q.delta_major};
      end else begin
        line_d.error_init = err_sum;
      end
      line_d.major_pos = line_q.major_pos + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q     <= line_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

>>> rtl/core/bresenham_line_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator_unit
// Path: an advance word is held in a queue slot, then its pixel word is
// taken into the output register.
// Throughput: one input word per cycle while the queue is not full, one
// pixel per cycle while the output is not stalled.
// Reset: rst_ni clears the queue, the busy flag and the output valid flag;
// the unit is idle and ready once reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_pixel_generator_unit #(
  parameter int unsigned QUEUE_DEPTH = lbg_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lbg_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lbg_pkg::out_word_t out_word_o
);
  import lbg_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  cmd_t front_cmd, back_cmd;

  lbg_front u_front (
    .in_word_i  (in_word_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (front_cmd)
  );

  lbg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (back_cmd)
  );

  lbg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (back_cmd),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/lbg_checker.sv
// ----------------------------------------------------------------------------
// lbg_checker
// Port-level checks for the line pixel generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lbg_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  lbg_pkg::in_word_t  in_word_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  lbg_pkg::out_word_t out_word_o
);
  import lbg_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // a free output side drains the queue by one
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stalled after a free output cycle");

  // reset leaves both sides quiet
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("activity during reset");

endmodule

bind bresenham_line_pixel_generator_unit lbg_checker u_lbg_checker (.*);

`default_nettype wire
